// ----- rtl/core/jess_pkg.sv -----
// shared types, constants and constant tables for the julia escape shader
package jess_pkg;

    // image and fixed-point geometry
    localparam int WIDTH_LOG2_DEF  = 10;
    localparam int HEIGHT_LOG2_DEF = 10;
    localparam int FRAC            = 26;
    localparam int COORD_W         = 10;

    // configuration register indexes
    localparam logic [1:0] CFG_C_REAL = 2'd0;
    localparam logic [1:0] CFG_C_IMAG = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;

    // register reset values
    localparam logic signed [31:0] C_REAL_RST = -32'sd187904819;
    localparam logic signed [31:0] C_IMAG_RST = 32'sd72517838;
    localparam logic [15:0]        LIMIT_RST  = 16'd1000;

    // escape radius squared in q52, phase step in q32 turns per unit of s
    localparam logic [63:0]        FOUR_Q52 = 64'h0040_0000_0000_0000;
    localparam logic signed [34:0] PHASE_K  = 35'sd68356528;

    // fraction bits handed to the log unit
    localparam logic [5:0] LOG_FB_MAG = 6'd52;
    localparam logic [5:0] LOG_FB_L1  = 6'd17;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'h4000_0000;

    // log unit request and status
    typedef struct packed {
        logic        start;
        logic [63:0] value;
        logic [5:0]  fbits;
    } t_log_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [23:0] result;
    } t_log_stat;

    typedef logic [15:0] t_log_tab [0:255];
    typedef logic [31:0] t_sin_tab [0:256];

    // log2(1 + i/256) in q16 by repeated squaring
    function automatic logic [15:0] frac_log(input int unsigned i);
        logic [63:0] y;
        logic [15:0] r;
        y = 64'(256 + i) << 22;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            r = {r[14:0], 1'b0};
            if (y >= 64'h8000_0000) begin
                r[0] = 1'b1;
                y    = y >> 1;
            end
        end
        return r;
    endfunction

    function automatic t_log_tab make_log_tab();
        t_log_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = frac_log(i);
        end
        return tab;
    endfunction

    // sin(j*pi/512) in q30, taylor series to x^11
    function automatic logic [31:0] quarter_sin(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (64'(j) * PI_Q30) >> 9;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        return 32'((x * t) >> 30);
    endfunction

    function automatic t_sin_tab make_sin_tab();
        t_sin_tab tab;
        for (int j = 0; j < 257; j++) begin
            tab[j] = quarter_sin(j);
        end
        return tab;
    endfunction

endpackage

// ----- rtl/core/jess_log2.sv -----
// bit-serial log2 unit: leading-one search plus fraction table, q16 result
module jess_log2 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jess_pkg::t_log_req  i_req,
    output jess_pkg::t_log_stat o_stat
);
    import jess_pkg::*;

    localparam t_log_tab LOG_TAB = make_log_tab();

    typedef enum logic {
        ST_IDLE,
        ST_NORM
    } t_state;

    t_state             r_state;
    logic [63:0]        r_v;
    logic [5:0]         r_p;
    logic [5:0]         r_fb;
    logic               r_done;
    logic signed [23:0] r_result;
    logic signed [7:0]  n_pexp;

    // integer part of the log
    assign n_pexp = $signed({2'b00, r_p}) - $signed({2'b00, r_fb});

    // sequencer: shift one bit a cycle until the leading one reaches the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_done <= i_req.start && (i_req.value == '0);
                    if (i_req.start) begin
                        r_v  <= i_req.value;
                        r_p  <= 6'd63;
                        r_fb <= i_req.fbits;
                        if (i_req.value == '0) begin
                            r_result <= '0;
                        end else begin
                            r_state <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    r_done <= r_v[63];
                    if (r_v[63]) begin
                        r_result <= {n_pexp, LOG_TAB[r_v[62:55]]};
                        r_state  <= ST_IDLE;
                    end else begin
                        r_v <= {r_v[62:0], 1'b0};
                        r_p <= r_p - 6'd1;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy   = (r_state == ST_NORM);
    assign o_stat.done   = r_done;
    assign o_stat.result = r_result;

endmodule

// ----- rtl/core/julia_escape_smooth_shade_top.sv -----
// julia set escape-time pixel shader with smooth grey-level shading
// One pixel is taken at a time; o_in_ready is low while it is worked on. Each
// escape iteration forms three products on the single shared 35x35 multiplier
// (ST_SQR, ST_SQI, ST_CRS), then does the add, compare and update (ST_UPD); up
// to iteration_limit iterations run (1000 by default). After an escape the
// bit-serial leading-one search of the log unit runs twice, followed by a
// phase multiply and a table lookup. The result waits in an output register
// until taken. Configuration writes are always accepted and must only be made
// while no pixel is in flight.
module julia_escape_smooth_shade_top #(
    parameter int WIDTH_LOG2  = jess_pkg::WIDTH_LOG2_DEF,
    parameter int HEIGHT_LOG2 = jess_pkg::HEIGHT_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [jess_pkg::COORD_W-1:0] i_pixel_x,
    input  logic [jess_pkg::COORD_W-1:0] i_pixel_y,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_shade,
    output logic                        o_escaped,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    import jess_pkg::*;

    localparam t_sin_tab SIN_TAB = make_sin_tab();
    localparam logic [31:0] X_MASK = 32'((64'd1 << WIDTH_LOG2) - 64'd1);
    localparam logic [31:0] Y_MASK = 32'((64'd1 << HEIGHT_LOG2) - 64'd1);
    localparam logic signed [31:0] HALF3 = 32'sd3 <<< (FRAC - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQR,
        ST_SQI,
        ST_CRS,
        ST_UPD,
        ST_LOG1,
        ST_LOG2,
        ST_PHASE,
        ST_SHADE,
        ST_OUT
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_c_real;
    logic signed [31:0] r_c_imag;
    logic [15:0]        r_limit;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic [15:0]        r_n;
    logic signed [63:0] r_sr;
    logic signed [63:0] r_si;
    logic signed [63:0] r_x;
    logic signed [34:0] r_s;
    logic [31:0]        r_phase;
    logic [7:0]         r_res_shade;
    logic               r_res_esc;
    logic               r_out_valid;
    logic [7:0]         r_out_shade;
    logic               r_out_esc;

    logic signed [34:0] n_ma;
    logic signed [34:0] n_mb;
    logic signed [69:0] n_prod;
    logic [63:0]        n_mag;
    logic               n_esc;
    logic signed [63:0] n_diff;
    logic signed [31:0] n_zr;
    logic signed [31:0] n_zi;
    logic [31:0]        n_px;
    logic [31:0]        n_py;
    logic signed [31:0] n_zr0;
    logic signed [31:0] n_zi0;
    logic [9:0]         n_idx;
    logic [8:0]         n_tj;
    logic signed [33:0] n_a;
    logic signed [33:0] n_ac;
    logic [41:0]        n_scaled;
    logic [10:0]        n_sh;
    logic [7:0]         n_shade;
    logic signed [34:0] n_s;
    logic               n_out_take;

    t_log_req  log_req;
    t_log_stat log_stat;

    jess_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (log_req),
        .o_stat  (log_stat)
    );

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real <= C_REAL_RST;
            r_c_imag <= C_IMAG_RST;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_C_REAL: r_c_real <= $signed(i_cfg_data);
                CFG_C_IMAG: r_c_imag <= $signed(i_cfg_data);
                CFG_LIMIT:  r_limit  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // start point of the orbit
    assign n_px  = 32'(i_pixel_x) & X_MASK;
    assign n_py  = 32'(i_pixel_y) & Y_MASK;
    assign n_zr0 = $signed(32'(n_px * 32'd3) << (FRAC - WIDTH_LOG2)) - HALF3;
    assign n_zi0 = $signed(32'(n_py * 32'd3) << (FRAC - HEIGHT_LOG2)) - HALF3;

    // shared multiplier operand select
    always_comb begin
        n_ma = 35'(r_zr);
        n_mb = 35'(r_zr);
        unique case (r_state)
            ST_SQI: begin
                n_ma = 35'(r_zi);
                n_mb = 35'(r_zi);
            end
            ST_CRS: begin
                n_ma = 35'(r_zr);
                n_mb = 35'(r_zi);
            end
            ST_PHASE: begin
                n_ma = r_s;
                n_mb = PHASE_K;
            end
            default: ;
        endcase
    end
    assign n_prod = n_ma * n_mb;

    // escape test and orbit update
    assign n_mag  = 64'(r_sr) + 64'(r_si);
    assign n_esc  = (n_mag > FOUR_Q52);
    assign n_diff = r_sr - r_si;
    assign n_zr   = $signed(n_diff[FRAC+31:FRAC]) + r_cr;
    assign n_zi   = $signed(r_x[FRAC+30:FRAC-1]) + r_ci;

    // log unit requests: first |z|^2, then the first result
    always_comb begin
        log_req.start = 1'b0;
        log_req.value = n_mag;
        log_req.fbits = LOG_FB_MAG;
        if (r_state == ST_UPD && n_esc) begin
            log_req.start = 1'b1;
        end else if (r_state == ST_LOG1 && log_stat.done) begin
            log_req.start = 1'b1;
            log_req.value = (log_stat.result > 24'sd0) ? 64'(log_stat.result) : '0;
            log_req.fbits = LOG_FB_L1;
        end
    end

    // smooth value
    assign n_s = $signed({2'b00, 17'(r_n) + 17'd1, 16'd0}) - 35'(log_stat.result);

    // quadrant folding and grey level
    assign n_idx = r_phase[31:22];
    assign n_tj  = n_idx[8] ? 9'(9'd256 - {1'b0, n_idx[7:0]}) : {1'b0, n_idx[7:0]};
    assign n_a   = n_idx[9] ? $signed(34'(ONE_Q30)) - $signed({2'b00, SIN_TAB[n_tj]})
                            : $signed(34'(ONE_Q30)) + $signed({2'b00, SIN_TAB[n_tj]});
    always_comb begin
        if (n_a < 34'sd0) begin
            n_ac = '0;
        end else if (n_a > $signed(34'(ONE_Q30 << 1))) begin
            n_ac = $signed(34'(ONE_Q30 << 1));
        end else begin
            n_ac = n_a;
        end
    end
    assign n_scaled = (42'(n_ac) << 8) - 42'(n_ac);
    assign n_sh     = n_scaled[41:31];
    assign n_shade  = (n_sh > 11'd255) ? 8'd255 : n_sh[7:0];

    assign n_out_take = !r_out_valid || i_out_ready;

    // pixel sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_zr    <= n_zr0;
                        r_zi    <= n_zi0;
                        r_cr    <= r_c_real >>> 2;
                        r_ci    <= r_c_imag >>> 2;
                        r_n     <= '0;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (r_n >= r_limit) begin
                        r_res_shade <= '0;
                        r_res_esc   <= 1'b0;
                        r_state     <= ST_OUT;
                    end else begin
                        r_sr    <= n_prod[63:0];
                        r_state <= ST_SQI;
                    end
                end
                ST_SQI: begin
                    r_si    <= n_prod[63:0];
                    r_state <= ST_CRS;
                end
                ST_CRS: begin
                    r_x     <= n_prod[63:0];
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (n_esc) begin
                        r_state <= ST_LOG1;
                    end else begin
                        r_zr    <= n_zr;
                        r_zi    <= n_zi;
                        r_n     <= r_n + 16'd1;
                        r_state <= ST_SQR;
                    end
                end
                ST_LOG1: begin
                    if (log_stat.done) begin
                        r_state <= ST_LOG2;
                    end
                end
                ST_LOG2: begin
                    if (log_stat.done) begin
                        r_s     <= n_s;
                        r_state <= ST_PHASE;
                    end
                end
                ST_PHASE: begin
                    r_phase <= n_prod[47:16];
                    r_state <= ST_SHADE;
                end
                ST_SHADE: begin
                    r_res_shade <= n_shade;
                    r_res_esc   <= 1'b1;
                    r_state     <= ST_OUT;
                end
                ST_OUT: begin
                    if (n_out_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && n_out_take) begin
            r_out_valid <= 1'b1;
            r_out_shade <= r_res_shade;
            r_out_esc   <= r_res_esc;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_shade     = r_out_shade;
    assign o_escaped   = r_out_esc;

    // a pixel that stays inside is always black
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_escaped) |-> (o_shade == 8'd0))
        else $error("non-escaped pixel with nonzero shade");

    // the iteration count never runs past the limit
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_n <= r_limit))
        else $error("iteration count beyond limit");

    // the log unit is only started while it is free
    a_log_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        log_req.start |-> !log_stat.busy)
        else $error("log unit started while busy");

endmodule

// ----- tb/sv/tb_julia_escape_smooth_shade_top.sv -----
// testbench for the julia escape shader: directed table, random phases, self-checking
`timescale 1ns / 100ps

module tb_julia_escape_smooth_shade_top;
    import jess_pkg::*;

    typedef struct {
        logic [7:0] shade;
        logic       escaped;
    } t_pix_res;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [31:0] data;
        logic [9:0]  x;
        logic [9:0]  y;
        bit          typed;
        logic [7:0]  shade;
        logic        escaped;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [9:0]  i_pixel_x;
    logic [9:0]  i_pixel_y;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_shade;
    logic        o_escaped;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // shadow copy of the registers
    logic signed [31:0] sh_c_real;
    logic signed [31:0] sh_c_imag;
    logic [15:0]        sh_limit;

    t_pix_res   shade_q[$];
    t_row       rows[$];
    int         err_cnt;
    bit         idle_on;
    bit         hold_req;
    logic [7:0] row_shade;
    logic       row_esc;
    bit         row_typed;

    julia_escape_smooth_shade_top dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // run limit
    initial begin
        #(64'd80_000_000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        err_cnt++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    // log2(1 + i/256) in q16 by squaring
    function automatic longint frac_log2(input int unsigned i);
        longint unsigned y;
        longint          r;
        y = longint'(256 + (i & 255)) << 22;
        r = 0;
        for (int k = 0; k < 16; k++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30)) begin
                r = r | 1;
                y = y >> 1;
            end
        end
        return r;
    endfunction

    function automatic longint log2_fix(input longint unsigned v, input int fb);
        int          p;
        int unsigned i;
        if (v == 0) return 0;
        p = 0;
        while (p < 63 && (v >> (p + 1)) != 0) p++;
        if (p >= 8) i = int'((v >> (p - 8)) & 255);
        else i = int'((v << (8 - p)) & 255);
        return longint'(p - fb) * 65536 + frac_log2(i);
    endfunction

    function automatic longint sine_q30(input int unsigned j);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned dv[5];
        dv = '{110, 72, 42, 20, 6};
        x  = (longint'(j) * 64'd3373259426) >> 9;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 0; k < 5; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
        return longint'((x * t) >> 30);
    endfunction

    // expected shade of one pixel under the shadow registers
    function automatic t_pix_res shade_of(input logic [9:0] px, input logic [9:0] py);
        t_pix_res        r;
        longint          zr, zi, cr, ci, sr, si, xprod, mag, n, l1, nu, s, sv, a;
        longint unsigned prod;
        logic [31:0]     phase;
        logic [9:0]      pidx;
        bit              esc;
        zr  = ((longint'(3 * px)) <<< 26) >>> 10;
        zr  = zr - (longint'(3) <<< 25);
        zi  = ((longint'(3 * py)) <<< 26) >>> 10;
        zi  = zi - (longint'(3) <<< 25);
        cr  = longint'(sh_c_real) >>> 2;
        ci  = longint'(sh_c_imag) >>> 2;
        n   = 0;
        mag = 0;
        esc = 0;
        while (n < longint'(sh_limit)) begin
            sr    = zr * zr;
            si    = zi * zi;
            xprod = 2 * zr * zi;
            mag   = sr + si;
            if (mag > (longint'(4) <<< 52)) begin
                esc = 1;
                break;
            end
            zr = ((sr - si) >>> 26) + cr;
            zi = (xprod >>> 26) + ci;
            n++;
        end
        r.shade   = 8'd0;
        r.escaped = esc;
        if (esc) begin
            l1    = log2_fix(mag, 52);
            nu    = log2_fix(l1 > 0 ? l1 : 0, 17);
            s     = (n + 1) * 65536 - nu;
            prod  = (longint'(s) * 64'd68356528) >> 16;
            phase = prod[31:0];
            pidx  = phase[31:22];
            sv    = pidx[8] ? sine_q30(256 - pidx[7:0]) : sine_q30(pidx[7:0]);
            if (pidx[9]) sv = -sv;
            a = (longint'(1) <<< 30) + sv;
            if (a < 0) a = 0;
            if (a > (longint'(1) <<< 31)) a = longint'(1) <<< 31;
            a = (a * 255) >>> 31;
            r.shade = (a > 255) ? 8'd255 : a[7:0];
        end
        return r;
    endfunction

    // one pixel request, with an optional random gap before it
    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        t_pix_res e;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= x;
        i_pixel_y  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        e = shade_of(x, y);
        if (row_typed) begin
            e.shade   = row_shade;
            e.escaped = row_esc;
        end
        shade_q.push_back(e);
    endtask

    // register write, only once every pixel has come back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (shade_q.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_C_REAL: sh_c_real = data;
            CFG_C_IMAG: sh_c_imag = data;
            CFG_LIMIT:  sh_limit  = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic row_cfg(input logic [1:0] idx, input logic [31:0] data);
        t_row r;
        r        = '{default: '0};
        r.is_cfg = 1;
        r.idx    = idx;
        r.data   = data;
        rows.push_back(r);
    endtask

    task automatic row_pix(input logic [9:0] x, input logic [9:0] y, input bit typed,
                           input logic [7:0] sh, input logic esc);
        t_row r;
        r         = '{default: '0};
        r.x       = x;
        r.y       = y;
        r.typed   = typed;
        r.shade   = sh;
        r.escaped = esc;
        rows.push_back(r);
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_pix_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (shade_q.size() == 0) begin
                report("unexpected result, shade", o_shade, -1);
            end else begin
                e = shade_q.pop_front();
                if (o_shade !== e.shade) report("shade", o_shade, e.shade);
                if (o_escaped !== e.escaped) report("escaped", o_escaped, e.escaped);
            end
        end
    end

    initial begin
        int         waited;
        logic [9:0] x, y;
        err_cnt     = 0;
        idle_on     = 1;
        hold_req    = 0;
        row_typed   = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_pixel_x   = '0;
        i_pixel_y   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_C_REAL;
        i_cfg_data  = '0;
        sh_c_real   = C_REAL_RST;
        sh_c_imag   = C_IMAG_RST;
        sh_limit    = LIMIT_RST;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        row_pix(10'd512, 10'd512, 0, 0, 0);
        row_pix(10'd0, 10'd0, 0, 0, 0);
        row_cfg(CFG_LIMIT, 32'd0);
        row_pix(10'd1023, 10'd1023, 1, 8'd0, 1'b0);
        row_pix(10'd0, 10'd0, 1, 8'd0, 1'b0);
        row_cfg(CFG_C_REAL, 32'd0);
        row_cfg(CFG_C_IMAG, 32'd0);
        row_cfg(CFG_LIMIT, 32'd20);
        row_pix(10'd512, 10'd512, 1, 8'd0, 1'b0);
        row_cfg(CFG_LIMIT, 32'd65535);
        row_pix(10'd0, 10'd0, 0, 0, 0);
        row_pix(10'd1023, 10'd0, 0, 0, 0);
        row_pix(10'd0, 10'd1023, 0, 0, 0);
        row_pix(10'd1023, 10'd1023, 0, 0, 0);
        row_cfg(CFG_C_REAL, 32'h7fff_ffff);
        row_cfg(CFG_C_IMAG, 32'h8000_0000);
        row_cfg(CFG_LIMIT, 32'd1000);
        row_pix(10'd512, 10'd512, 0, 0, 0);
        row_pix(10'd300, 10'd700, 0, 0, 0);
        row_cfg(CFG_C_REAL, 32'h8000_0000);
        row_cfg(CFG_C_IMAG, 32'h7fff_ffff);
        row_pix(10'd511, 10'd1, 0, 0, 0);
        row_cfg(CFG_C_REAL, C_REAL_RST);
        row_cfg(CFG_C_IMAG, C_IMAG_RST);
        row_pix(10'd512, 10'd512, 0, 0, 0);
        row_pix(10'd170, 10'd853, 0, 0, 0);
        row_pix(10'd682, 10'd341, 0, 0, 0);
        foreach (rows[k]) begin
            if (rows[k].is_cfg) begin
                write_reg(rows[k].idx, rows[k].data);
            end else begin
                row_typed = rows[k].typed;
                row_shade = rows[k].shade;
                row_esc   = rows[k].escaped;
                send_pixel(rows[k].x, rows[k].y);
            end
        end
        row_typed = 0;

        // random phases, each under its own constant and limit
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) idle_on = 0;
            if (ph % 2 == 0) begin
                write_reg(CFG_C_REAL, $urandom);
                write_reg(CFG_C_IMAG, $urandom);
            end else begin
                write_reg(CFG_C_REAL, $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
                write_reg(CFG_C_IMAG, $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
            end
            write_reg(CFG_LIMIT, (ph == 3) ? 200 : $urandom_range(1, 64));
            for (int k = 0; k < 100; k++) begin
                if (ph == 2 && k == 10) hold_req = 1;
                x = 10'($urandom);
                y = 10'($urandom);
                send_pixel(x, y);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain
        waited = 0;
        while (shade_q.size() != 0 && waited < 2_000_000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (200) @(negedge i_clk);
        if (err_cnt == 0 && shade_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/jess_pkg.sv
rtl/core/jess_log2.sv
rtl/core/julia_escape_smooth_shade_top.sv
tb/sv/tb_julia_escape_smooth_shade_top.sv
